// ===== rtl/lcg48_pkg.sv =====
package lcg48_pkg;

  localparam int StateW = 48;
  localparam int DrawW  = 31;
  localparam int ValueW = 32;

  localparam logic [StateW-1:0] LCG_MULT = 48'h0005_DEEC_E66D;
  localparam logic [StateW-1:0] LCG_ADD  = 48'h0000_0000_000B;

  typedef logic [1:0] opcode_t;

  localparam opcode_t OP_RESEED  = 2'd0;
  localparam opcode_t OP_RAW     = 2'd1;
  localparam opcode_t OP_BOUNDED = 2'd2;

  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_RAW,
    SEL_POW2,
    SEL_MOD
  } out_sel_t;

  typedef struct packed {
    logic     load;
    logic     reseed;
    logic     mul_step;
    logic     mul_last;
    logic [1:0] mul_idx;
    logic     div_start;
    logic     div_step;
    logic     out_load;
    out_sel_t out_sel;
  } dp_cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    bound_nonpos;
    logic    bound_pow2;
    logic    reject;
  } dp_status_t;

endpackage

// ===== rtl/lcg48_dp.sv =====
module lcg48_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  lcg48_pkg::dp_cmd_t    cmd,
  output lcg48_pkg::dp_status_t status,
  input  logic [1:0]           opcode,
  input  logic [47:0]          seed_value,
  input  logic [5:0]           bit_count,
  input  logic signed [31:0]   bound,
  output logic signed [31:0]   value
);
  import lcg48_pkg::*;

  opcode_t           op;
  logic [StateW-1:0] seed;
  logic [5:0]        bc;
  logic [ValueW-1:0] bnd;
  logic [StateW-1:0] lcg_state;
  logic [StateW-1:0] acc;
  logic [DrawW-1:0]  u;
  logic [DrawW-1:0]  u_sh;
  logic [ValueW-1:0] rem;

  logic [15:0]       chunk;
  logic [50:0]       pp;
  logic [StateW-1:0] pp_sh;
  logic [StateW-1:0] acc_base;
  logic [StateW-1:0] acc_sum;
  logic [ValueW-1:0] rem_shift;
  logic [ValueW-1:0] chk;
  logic [62:0]       pprod;
  logic [5:0]        n_clamp;
  logic [5:0]        shamt;
  logic [StateW-1:0] raw_sh;
  logic [DrawW-1:0]  draw;

  assign draw = lcg_state[StateW-1 -: DrawW];

  // one 16-bit slice of the state times the multiplier per step
  always_comb begin
    case (cmd.mul_idx)
      2'd0:    chunk = lcg_state[15:0];
      2'd1:    chunk = lcg_state[31:16];
      2'd2:    chunk = lcg_state[47:32];
      default: chunk = '0;
    endcase
    pp = 51'(chunk) * 51'(LCG_MULT[34:0]);
    case (cmd.mul_idx)
      2'd0:    pp_sh = pp[47:0];
      2'd1:    pp_sh = {pp[31:0], 16'b0};
      2'd2:    pp_sh = {pp[15:0], 32'b0};
      default: pp_sh = '0;
    endcase
    acc_base = (cmd.mul_idx == 2'd0) ? LCG_ADD : acc;
    acc_sum  = acc_base + pp_sh;
  end

  assign rem_shift = {rem[ValueW-2:0], u_sh[DrawW-1]};
  assign chk       = 32'(u) - rem + bnd - 32'd1;
  assign pprod     = 63'(bnd[30:0]) * 63'(draw);

  always_comb begin
    if (bc == 6'd0) begin
      n_clamp = 6'd1;
    end else if (bc > 6'd32) begin
      n_clamp = 6'd32;
    end else begin
      n_clamp = bc;
    end
    shamt  = 6'd48 - n_clamp;
    raw_sh = lcg_state >> shamt;
  end

  assign status.op           = op;
  assign status.bound_nonpos = (bnd == '0) || bnd[ValueW-1];
  assign status.bound_pow2   = ((bnd & (bnd - 32'd1)) == '0);
  assign status.reject       = chk[ValueW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      lcg_state <= LCG_MULT;
    end else if (cmd.reseed) begin
      lcg_state <= seed ^ LCG_MULT;
    end else if (cmd.mul_step && cmd.mul_last) begin
      lcg_state <= acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= opcode;
      seed <= seed_value;
      bc   <= bit_count;
      bnd  <= bound;
    end
    if (cmd.mul_step) begin
      acc <= acc_sum;
    end
    // restoring remainder, one bit of the draw per cycle
    if (cmd.div_start) begin
      u    <= draw;
      u_sh <= draw;
      rem  <= '0;
    end else if (cmd.div_step) begin
      u_sh <= {u_sh[DrawW-2:0], 1'b0};
      if (rem_shift >= bnd) begin
        rem <= rem_shift - bnd;
      end else begin
        rem <= rem_shift;
      end
    end
    if (cmd.out_load) begin
      case (cmd.out_sel)
        SEL_RAW:  value <= raw_sh[ValueW-1:0];
        SEL_POW2: value <= pprod[62:31];
        SEL_MOD:  value <= rem;
        default:  value <= '0;
      endcase
    end
  end

endmodule

// ===== rtl/lcg48_ctrl.sv =====
module lcg48_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lcg48_pkg::dp_cmd_t    cmd,
  input  lcg48_pkg::dp_status_t status
);
  import lcg48_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_MUL,
    S_EVAL,
    S_DIV,
    S_CHECK,
    S_FINISH
  } state_t;

  state_t   state;
  logic [4:0] cnt;
  out_sel_t sel;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd         = '0;
    cmd.mul_idx = cnt[1:0];
    cmd.out_sel = sel;
    case (state)
      S_IDLE:     cmd.load = in_valid;
      S_DISPATCH: cmd.reseed = (status.op == OP_RESEED);
      S_MUL: begin
        cmd.mul_step = 1'b1;
        cmd.mul_last = (cnt == 5'd2);
      end
      S_EVAL:     cmd.div_start = (status.op == OP_BOUNDED) && !status.bound_pow2;
      S_DIV:      cmd.div_step = 1'b1;
      S_FINISH:   cmd.out_load = !out_valid || out_ready;
      default:    cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      sel       <= SEL_ZERO;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          cnt <= '0;
          if (status.op == OP_RAW) begin
            state <= S_MUL;
          end else if (status.op == OP_BOUNDED) begin
            if (status.bound_nonpos) begin
              sel   <= SEL_ZERO;
              state <= S_FINISH;
            end else begin
              state <= S_MUL;
            end
          end else begin
            state <= S_IDLE;
          end
        end
        S_MUL: begin
          if (cnt == 5'd2) begin
            cnt   <= '0;
            state <= S_EVAL;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_EVAL: begin
          if (status.op == OP_RAW) begin
            sel   <= SEL_RAW;
            state <= S_FINISH;
          end else if (status.bound_pow2) begin
            sel   <= SEL_POW2;
            state <= S_FINISH;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (cnt == 5'(DrawW - 1)) begin
            cnt   <= '0;
            state <= S_CHECK;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_CHECK: begin
          // redraw while the remainder falls in the biased top range
          if (status.reject) begin
            state <= S_MUL;
          end else begin
            sel   <= SEL_MOD;
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (cmd.out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/lcg48_random_with_bounded_int_core.sv =====
// 48-bit linear congruential generator with raw and bounded draws.
// input channel (in_valid/in_ready): opcode, seed_value, bit_count, bound.
//   opcode 0 reseeds and gives no result, 1 gives the top bit_count bits
//   (clamped to 1..32) of the advanced state, 2 gives an integer in
//   [0, bound) or 0 for a non-positive bound, opcode 3 is dropped with no result.
// output channel (out_valid/out_ready): value, one transfer per draw.
// one item is taken at a time; in_ready is high only while the block waits.
// path from the input transfer: a reseed passes dispatch and returns to idle;
//   a raw draw and a power-of-two bound pass dispatch, the 3-step state
//   multiply, evaluate and finish; a non-positive bound goes from dispatch
//   straight to finish. other bounds add the 31-step bit-serial remainder
//   and a check after evaluate; each rejected draw goes back to the state
//   multiply for another attempt.
// the result sits in an output register, so the block finishes its work
//   while the previous result waits; a stalled receiver holds the next
//   result in the final state and keeps in_ready low.
// reset (rst, synchronous) loads the state with the seed-zero value and
//   drops any pending result.
module lcg48_random_with_bounded_int_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic [47:0]        seed_value,
  input  logic [5:0]         bit_count,
  input  logic signed [31:0] bound,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] value
);
  import lcg48_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  lcg48_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  lcg48_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .opcode     (opcode),
    .seed_value (seed_value),
    .bit_count  (bit_count),
    .bound      (bound),
    .value      (value)
  );

endmodule
